FILE: hw/rtl/cmred_pkg.sv
// ----------------------------------------------------------------------------
// cmred_pkg
// Shared types and constants for the color mask row edge detector.
// ----------------------------------------------------------------------------
package cmred_pkg;

  localparam int FRAME_ROWS_I = 520;
  localparam int ROW_PIXELS_I = 240;
  localparam int MAX_POLES_I  = 128;

  localparam int POLE_CAP_I   = (MAX_POLES_I > 128) ? 128 :
                                ((MAX_POLES_I < 1) ? 1 : MAX_POLES_I);

  // row length in macropixels, frame length in rows, pole index cap
  localparam logic [6:0]  MACROS_PER_ROW = 7'((ROW_PIXELS_I + 1) / 2);
  localparam logic [10:0] FRAME_ROWS     = 11'(FRAME_ROWS_I);
  localparam logic [7:0]  POLE_CAP       = 8'(POLE_CAP_I);

  localparam logic [7:0]  OVL_CHROMA = 8'd128;
  localparam logic [7:0]  OVL_LUMA   = 8'd255;

  localparam int OUT_TDATA_W = 56;
  localparam int IN_TDATA_W  = 32;

  typedef enum logic [1:0] {
    KIND_OVERLAY = 2'd0,
    KIND_START   = 2'd1,
    KIND_END     = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    REG_LUMA_MIN  = 3'd0,
    REG_LUMA_MAX  = 3'd1,
    REG_BLUE_MIN  = 3'd2,
    REG_BLUE_MAX  = 3'd3,
    REG_RED_MIN   = 3'd4,
    REG_RED_MAX   = 3'd5,
    REG_EDGE_THR  = 3'd6,
    REG_SKIP_ROWS = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] luma_min;
    logic [7:0] luma_max;
    logic [7:0] blue_diff_min;
    logic [7:0] blue_diff_max;
    logic [7:0] red_diff_min;
    logic [7:0] red_diff_max;
    logic [7:0] edge_threshold;
    logic [7:0] skip_rows;
  } cfg_t;

  typedef struct packed {
    logic [7:0] u;
    logic [7:0] y0;
    logic [7:0] v;
    logic [7:0] y1;
    logic       mask;
  } ovl_t;

  typedef struct packed {
    logic       hit;
    kind_t      kind;
    logic [9:0] row;
    logic [6:0] pole_index;
    logic       pole_overflow;
  } edge_ev_t;

endpackage

FILE: hw/rtl/color_mask_row_edge_detector_unit.sv
// ----------------------------------------------------------------------------
// color_mask_row_edge_detector_unit
// UYVY color window mask with overlay output and row projection pole edges.
// ----------------------------------------------------------------------------
//  channel | dir | tdata / data                            | tuser  | tlast
//  in_     | in  | u, y_first, v, y_second (8 b each)      | -      | -
//  out_    | out | u, y_first, v, y_second, mask, row,     | kind   | last of
//          |     | pole index, overflow                    |        | input
//  cfg_    | in  | index 3 b, data 8 b                     | -      | -
//
//  One item per cycle enters the input register while the result register
//  keeps draining; compare/add logic feeds the result register. An input that
//  ends a row with an edge gives two results and so holds the result register
//  until both are taken; otherwise it gives one result.
//  Stalls on out_tready propagate back through in_tready; one item waits in
//  the input register while a finished result waits downstream.
//  Reset (synchronous, rst_n low) clears all counters and loads default
//  thresholds.
// ----------------------------------------------------------------------------
module color_mask_row_edge_detector_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [7:0] chroma_u, [15:8] luma_first, [23:16] chroma_v, [31:24] luma_second
  input  logic [cmred_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [7:0] out_u, [15:8] out_y_first, [23:16] out_v, [31:24] out_y_second,
  // [32] in_mask, [42:33] edge_row, [49:43] pole_index, [50] pole_overflow,
  // [55:51] zero
  output logic [cmred_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // [1:0] kind
  output logic [1:0]                         out_tuser,
  output logic                               out_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  cmred_pkg::reg_idx_t                cfg_index,
  input  logic [7:0]                         cfg_data
);
  import cmred_pkg::*;

  cfg_t                  cfg_r;
  logic                  in_valid_r;
  logic [IN_TDATA_W-1:0] in_data_r;
  logic                  free;
  logic                  advance;
  ovl_t                  ovl;
  edge_ev_t              ev;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid_r && free;
  assign in_tready = !in_valid_r || free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.luma_min       <= 8'd26;
      cfg_r.luma_max       <= 8'd164;
      cfg_r.blue_diff_min  <= 8'd45;
      cfg_r.blue_diff_max  <= 8'd130;
      cfg_r.red_diff_min   <= 8'd160;
      cfg_r.red_diff_max   <= 8'd192;
      cfg_r.edge_threshold <= 8'd34;
      cfg_r.skip_rows      <= 8'd8;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LUMA_MIN:  cfg_r.luma_min       <= cfg_data;
        REG_LUMA_MAX:  cfg_r.luma_max       <= cfg_data;
        REG_BLUE_MIN:  cfg_r.blue_diff_min  <= cfg_data;
        REG_BLUE_MAX:  cfg_r.blue_diff_max  <= cfg_data;
        REG_RED_MIN:   cfg_r.red_diff_min   <= cfg_data;
        REG_RED_MAX:   cfg_r.red_diff_max   <= cfg_data;
        REG_EDGE_THR:  cfg_r.edge_threshold <= cfg_data;
        REG_SKIP_ROWS: cfg_r.skip_rows      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata;
    end
  end

  cmred_window u_window (
    .cfg (cfg_r),
    .u   (in_data_r[7:0]),
    .y0  (in_data_r[15:8]),
    .v   (in_data_r[23:16]),
    .y1  (in_data_r[31:24]),
    .ovl (ovl)
  );

  cmred_rowproj u_rowproj (
    .clk            (clk),
    .rst_n          (rst_n),
    .advance        (advance),
    .match          (ovl.mask),
    .edge_threshold (cfg_r.edge_threshold),
    .skip_rows      (cfg_r.skip_rows),
    .ev             (ev)
  );

  cmred_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .ovl        (ovl),
    .ev         (ev),
    .free       (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // a held input item stays until it moves into the result register
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_data_r))
    else $error("input item dropped");

endmodule

FILE: hw/rtl/cmred_window.sv
// ----------------------------------------------------------------------------
// cmred_window
// Y/U/V window test of one macropixel and the overlay bytes it produces.
// ----------------------------------------------------------------------------
module cmred_window (
  input  cmred_pkg::cfg_t cfg,
  input  logic [7:0]      u,
  input  logic [7:0]      y0,
  input  logic [7:0]      v,
  input  logic [7:0]      y1,
  output cmred_pkg::ovl_t ovl
);
  import cmred_pkg::*;

  logic match;

  // an inverted window always fails at least one compare on that side, so never matches
  assign match = (y0 >= cfg.luma_min)      && (y0 <= cfg.luma_max) &&
                 (u  >= cfg.blue_diff_min) && (u  <= cfg.blue_diff_max) &&
                 (v  >= cfg.red_diff_min)  && (v  <= cfg.red_diff_max);

  always_comb begin
    ovl.u    = match ? OVL_CHROMA : u;
    ovl.y0   = match ? OVL_LUMA   : y0;
    ovl.v    = match ? OVL_CHROMA : v;
    ovl.y1   = match ? OVL_LUMA   : y1;
    ovl.mask = match;
  end

endmodule

FILE: hw/rtl/cmred_rowproj.sv
// ----------------------------------------------------------------------------
// cmred_rowproj
// Per-row match count, two-rows-back difference, edge decision and
// row/skip/pole bookkeeping.
// ----------------------------------------------------------------------------
module cmred_rowproj (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  logic                match,
  input  logic [7:0]          edge_threshold,
  input  logic [7:0]          skip_rows,
  output cmred_pkg::edge_ev_t ev
);
  import cmred_pkg::*;

  logic [7:0]  acc_r, acc_nxt;
  logic [7:0]  back1_r, back1_nxt;
  logic [7:0]  back2_r, back2_nxt;
  logic [6:0]  col_r, col_nxt;
  logic [9:0]  row_r, row_nxt;
  logic [7:0]  skip_r, skip_nxt;
  logic [7:0]  pole_r, pole_nxt;

  logic [8:0]  acc_inc;
  logic [7:0]  acc_cur;
  logic [6:0]  col_inc;
  logic        row_end;
  logic [8:0]  diff;
  logic [8:0]  mag;
  logic        hit;
  logic        ovf;
  logic [10:0] row_inc;
  logic        frame_end;

  always_comb begin
    acc_inc   = {1'b0, acc_r} + 9'd2;
    acc_cur   = match ? (acc_inc[8] ? 8'hFF : acc_inc[7:0]) : acc_r;
    col_inc   = col_r + 7'd1;
    row_end   = (col_inc >= MACROS_PER_ROW);
    diff      = {1'b0, acc_cur} - {1'b0, back2_r};
    mag       = diff[8] ? (9'd0 - diff) : diff;
    hit       = row_end && (row_r >= 10'd2) && (skip_r == 8'd0) &&
                (mag > {1'b0, edge_threshold});
    ovf       = (pole_r >= POLE_CAP);
    row_inc   = {1'b0, row_r} + 11'd1;
    frame_end = (row_inc >= FRAME_ROWS);

    ev.hit           = hit;
    ev.kind          = diff[8] ? KIND_END : KIND_START;
    ev.row           = row_r - 10'd1;
    ev.pole_index    = ovf ? 7'(POLE_CAP - 8'd1) : pole_r[6:0];
    ev.pole_overflow = ovf;

    acc_nxt   = acc_cur;
    back1_nxt = back1_r;
    back2_nxt = back2_r;
    col_nxt   = col_inc;
    row_nxt   = row_r;
    skip_nxt  = skip_r;
    pole_nxt  = pole_r;

    if (row_end) begin
      if (row_r >= 10'd2) begin
        if (skip_r != 8'd0) begin
          skip_nxt = skip_r - 8'd1;
        end else if (hit) begin
          skip_nxt = skip_rows;
          if (diff[8] && !ovf) begin
            pole_nxt = pole_r + 8'd1;
          end
        end
      end
      back2_nxt = back1_r;
      back1_nxt = acc_cur;
      acc_nxt   = 8'd0;
      col_nxt   = 7'd0;
      row_nxt   = row_inc[9:0];
      if (frame_end) begin
        row_nxt  = 10'd0;
        skip_nxt = 8'd0;
        pole_nxt = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= 8'd0;
      back1_r <= 8'd0;
      back2_r <= 8'd0;
      col_r   <= 7'd0;
      row_r   <= 10'd0;
      skip_r  <= 8'd0;
      pole_r  <= 8'd0;
    end else if (advance) begin
      acc_r   <= acc_nxt;
      back1_r <= back1_nxt;
      back2_r <= back2_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      skip_r  <= skip_nxt;
      pole_r  <= pole_nxt;
    end
  end

  // pole count never passes the cap
  a_pole_capped: assert property (@(posedge clk) disable iff (!rst_n)
    pole_r <= POLE_CAP)
    else $error("pole counter above cap");

  // an edge outside the last row of a frame resets the skip window to the configured length
  a_skip_load: assert property (@(posedge clk) disable iff (!rst_n)
    advance && hit && !frame_end |=> skip_r == $past(skip_rows))
    else $error("skip counter not loaded after edge");

endmodule

FILE: hw/rtl/cmred_out_stage.sv
// ----------------------------------------------------------------------------
// cmred_out_stage
// Result register: holds the overlay item and an optional edge item of one
// input and hands them out in that order.
// ----------------------------------------------------------------------------
module cmred_out_stage (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  cmred_pkg::ovl_t               ovl,
  input  cmred_pkg::edge_ev_t           ev,
  output logic                          free,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [cmred_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [1:0]                    out_tuser,
  output logic                          out_tlast
);
  import cmred_pkg::*;

  logic     valid_r;
  logic     phase_r;   // 0: overlay item, 1: edge item
  ovl_t     ovl_r;
  edge_ev_t ev_r;
  logic     pop;
  logic     last_pop;

  assign pop      = valid_r && out_tready;
  assign last_pop = pop && (phase_r || !ev_r.hit);
  assign free     = !valid_r || last_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
      phase_r <= 1'b0;
    end else if (last_pop) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else if (pop) begin
      phase_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ovl_r <= ovl;
      ev_r  <= ev;
    end
  end

  always_comb begin
    out_tvalid = valid_r;
    out_tdata  = '0;
    if (phase_r) begin
      out_tuser        = ev_r.kind;
      out_tlast        = 1'b1;
      out_tdata[42:33] = ev_r.row;
      out_tdata[49:43] = ev_r.pole_index;
      out_tdata[50]    = ev_r.pole_overflow;
    end else begin
      out_tuser        = KIND_OVERLAY;
      out_tlast        = !ev_r.hit;
      out_tdata[7:0]   = ovl_r.u;
      out_tdata[15:8]  = ovl_r.y0;
      out_tdata[23:16] = ovl_r.v;
      out_tdata[31:24] = ovl_r.y1;
      out_tdata[32]    = ovl_r.mask;
    end
  end

  // the edge phase exists only for an input that produced an edge
  a_phase_edge: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && phase_r |-> ev_r.hit)
    else $error("edge phase without edge");

  // a new pair never lands on a result still owed downstream
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free)
    else $error("result register overwritten");

endmodule

FILE: tb/cmred_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmred_result_checker
// Watches the input, result and register channels of the color mask row edge
// detector, keeps its own model of the windows, row sums and pole counter,
// and checks every result item field by field against the oldest one due.
// ----------------------------------------------------------------------------
module cmred_result_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  input  logic [cmred_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic [cmred_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic [1:0]                          out_tuser,
  input  logic                                out_tlast,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  cmred_pkg::reg_idx_t                 cfg_index,
  input  logic [7:0]                          cfg_data,
  output int                                  mismatch_count,
  output int                                  outstanding,
  output int                                  results_checked,
  output int                                  edge_results,
  output int                                  overflow_edges
);
  import cmred_pkg::*;

  typedef struct {
    kind_t      kind;
    logic [7:0] u;
    logic [7:0] y_first;
    logic [7:0] v;
    logic [7:0] y_second;
    logic       mask;
    logic [9:0] row;
    logic [6:0] pole;
    logic       overflow;
    logic       last;
  } detector_out_t;

  cfg_t          window;
  logic [7:0]    row_sum, sum_prev, sum_prev2, skip_left, poles;
  logic [6:0]    col;
  logic [9:0]    row_idx;
  detector_out_t due_results[$];

  initial begin
    mismatch_count  = 0;
    outstanding     = 0;
    results_checked = 0;
    edge_results    = 0;
    overflow_edges  = 0;
  end

  function automatic string describe(detector_out_t r);
    return $sformatf({"kind=%0d u=%0d y0=%0d v=%0d y1=%0d mask=%0d row=%0d ",
                      "pole=%0d ovf=%0d last=%0d"},
                     r.kind, r.u, r.y_first, r.v, r.y_second, r.mask, r.row, r.pole,
                     r.overflow, r.last);
  endfunction

  task clear_model();
    window.luma_min       = 8'd26;
    window.luma_max       = 8'd164;
    window.blue_diff_min  = 8'd45;
    window.blue_diff_max  = 8'd130;
    window.red_diff_min   = 8'd160;
    window.red_diff_max   = 8'd192;
    window.edge_threshold = 8'd34;
    window.skip_rows      = 8'd8;
    row_sum   = '0;
    sum_prev  = '0;
    sum_prev2 = '0;
    skip_left = '0;
    poles     = '0;
    col       = '0;
    row_idx   = '0;
    due_results.delete();
  endtask

  task write_setting(input reg_idx_t idx, input logic [7:0] val);
    case (idx)
      REG_LUMA_MIN:  window.luma_min       = val;
      REG_LUMA_MAX:  window.luma_max       = val;
      REG_BLUE_MIN:  window.blue_diff_min  = val;
      REG_BLUE_MAX:  window.blue_diff_max  = val;
      REG_RED_MIN:   window.red_diff_min   = val;
      REG_RED_MAX:   window.red_diff_max   = val;
      REG_EDGE_THR:  window.edge_threshold = val;
      REG_SKIP_ROWS: window.skip_rows      = val;
      default: ;
    endcase
  endtask

  task predict_macropixel(input logic [7:0] u, y0, v, y1);
    detector_out_t ovl, edg;
    bit            hit, found;
    int            diff, mag;
    logic [10:0]   next_row;
    hit = (y0 >= window.luma_min) && (y0 <= window.luma_max) &&
          (u >= window.blue_diff_min) && (u <= window.blue_diff_max) &&
          (v >= window.red_diff_min) && (v <= window.red_diff_max);
    ovl.kind     = KIND_OVERLAY;
    ovl.u        = hit ? OVL_CHROMA : u;
    ovl.y_first  = hit ? OVL_LUMA : y0;
    ovl.v        = hit ? OVL_CHROMA : v;
    ovl.y_second = hit ? OVL_LUMA : y1;
    ovl.mask     = hit;
    ovl.row      = '0;
    ovl.pole     = '0;
    ovl.overflow = 1'b0;
    edg.kind     = KIND_START;
    edg.u        = '0;
    edg.y_first  = '0;
    edg.v        = '0;
    edg.y_second = '0;
    edg.mask     = 1'b0;
    edg.row      = '0;
    edg.pole     = '0;
    edg.overflow = 1'b0;
    edg.last     = 1'b1;
    found = 1'b0;

    if (hit) row_sum = (row_sum > 8'd253) ? 8'd255 : row_sum + 8'd2;
    col = col + 7'd1;
    if (col >= MACROS_PER_ROW) begin
      // rows 0 and 1 of a frame have no row two back to compare with
      if (row_idx >= 10'd2) begin
        if (skip_left != 8'd0) begin
          skip_left = skip_left - 8'd1;
        end else begin
          diff = int'(row_sum) - int'(sum_prev2);
          mag  = (diff < 0) ? -diff : diff;
          if (mag > int'(window.edge_threshold)) begin
            found        = 1'b1;
            edg.kind     = (diff > 0) ? KIND_START : KIND_END;
            edg.row      = row_idx - 10'd1;
            edg.overflow = (poles >= POLE_CAP);
            edg.pole     = edg.overflow ? 7'(POLE_CAP - 8'd1) : poles[6:0];
            if (diff < 0 && poles < POLE_CAP) poles = poles + 8'd1;
            skip_left = window.skip_rows;
          end
        end
      end
      sum_prev2 = sum_prev;
      sum_prev  = row_sum;
      row_sum   = '0;
      col       = '0;
      next_row  = {1'b0, row_idx} + 11'd1;
      if (next_row >= FRAME_ROWS) begin
        row_idx   = '0;
        skip_left = '0;
        poles     = '0;
      end else begin
        row_idx = next_row[9:0];
      end
    end

    ovl.last = !found;
    due_results.push_back(ovl);
    if (found) due_results.push_back(edg);
  endtask

  task check_result();
    detector_out_t got, want;
    bit            bad;
    got.kind     = kind_t'(out_tuser);
    got.u        = out_tdata[7:0];
    got.y_first  = out_tdata[15:8];
    got.v        = out_tdata[23:16];
    got.y_second = out_tdata[31:24];
    got.mask     = out_tdata[32];
    got.row      = out_tdata[42:33];
    got.pole     = out_tdata[49:43];
    got.overflow = out_tdata[50];
    got.last     = out_tlast;
    results_checked++;
    if (got.kind != KIND_OVERLAY) edge_results++;
    if (got.overflow) overflow_edges++;
    if (due_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: unexpected result item: %s", $realtime, describe(got));
      return;
    end
    want = due_results.pop_front();
    bad = (got.kind != want.kind) || (got.u != want.u) || (got.y_first != want.y_first) ||
          (got.v != want.v) || (got.y_second != want.y_second) ||
          (got.mask != want.mask) || (got.row != want.row) || (got.pole != want.pole) ||
          (got.overflow != want.overflow) || (got.last != want.last) ||
          (out_tdata[OUT_TDATA_W-1:51] != '0);
    if (bad) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("%0t: result mismatch, expected %s", $realtime, describe(want));
        $display("%0t:                  actual   %s pad=%0h", $realtime, describe(got),
                 out_tdata[OUT_TDATA_W-1:51]);
      end
    end
  endtask

  // inputs are taken before results so a combinational input-to-result path would still line up
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_model();
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) write_setting(cfg_index, cfg_data);
      if (in_tvalid && in_tready)
        predict_macropixel(in_tdata[7:0], in_tdata[15:8], in_tdata[23:16], in_tdata[31:24]);
      if (out_tvalid && out_tready) check_result();
      outstanding <= due_results.size();
    end
  end

endmodule

FILE: tb/color_mask_row_edge_detector_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_mask_row_edge_detector_unit_tb
// Drives UYVY macropixels and register writes into the detector with random
// gaps on both channels. A directed set probes the window bounds at reset
// values; random rows of varying match density follow under five register
// settings; a short striped run then gives clean pole start and end edges.
// ----------------------------------------------------------------------------
module color_mask_row_edge_detector_unit_tb;
  import cmred_pkg::*;

  typedef enum int {PACE_FULL, PACE_SPARSE, PACE_NONE} pace_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;
  logic                   out_tlast;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  reg_idx_t               cfg_index  = REG_LUMA_MIN;
  logic [7:0]             cfg_data   = '0;

  int         mismatch_count, outstanding, results_checked, edge_results, overflow_edges;
  pace_t      pace        = PACE_FULL;
  logic [7:0] setting [8];
  int         row_pos     = 0;
  int         stripe_row  = 0;
  int         items_sent  = 0;
  int         stall_left  = 0;
  int         next_stall;
  int         densities [5] = '{0, 100, 50, 10, 90};

  color_mask_row_edge_detector_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  cmred_result_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .edge_results    (edge_results),
    .overflow_edges  (overflow_edges)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int draw_gap();
    case (pace)
      PACE_NONE:   return 0;
      PACE_SPARSE: return ($urandom_range(0, 15) == 0) ? $urandom_range(1, 18) : 0;
      default:     return $urandom_range(0, 18);
    endcase
  endfunction

  function automatic logic [7:0] pick_inside(input int lo, input int hi);
    if (lo > hi) return 8'($urandom());
    return 8'($urandom_range(hi, lo));
  endfunction

  function automatic logic [7:0] pick_outside(input int lo, input int hi);
    if (lo > hi || (lo == 0 && hi == 255)) return 8'($urandom());
    if (lo == 0) return 8'($urandom_range(255, hi + 1));
    if (hi == 255) return 8'($urandom_range(lo - 1, 0));
    return ($urandom_range(0, 1) == 0) ? 8'($urandom_range(lo - 1, 0))
                                       : 8'($urandom_range(255, hi + 1));
  endfunction

  function automatic bit spans_all(input logic [7:0] lo, input logic [7:0] hi);
    return (lo == 8'd0) && (hi == 8'd255);
  endfunction

  // result side: a fresh stall is drawn after every accepted result item
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= (stall_left == 1);
    end else if (out_tvalid && out_tready) begin
      next_stall = draw_gap();
      stall_left <= next_stall;
      out_tready <= (next_stall == 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_item(input logic [7:0] u, y0, v, y1);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {y1, v, y0, u};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    row_pos = (row_pos + 1 == int'(MACROS_PER_ROW)) ? 0 : row_pos + 1;
  endtask

  // the task waits on the clock first so the checker's count includes the last accepted item
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [7:0] l_lo, l_hi, b_lo, b_hi, r_lo, r_hi,
                                input logic [7:0] thr, skip);
    drain_results();
    setting[REG_LUMA_MIN]  = l_lo;
    setting[REG_LUMA_MAX]  = l_hi;
    setting[REG_BLUE_MIN]  = b_lo;
    setting[REG_BLUE_MAX]  = b_hi;
    setting[REG_RED_MIN]   = r_lo;
    setting[REG_RED_MAX]   = r_hi;
    setting[REG_EDGE_THR]  = thr;
    setting[REG_SKIP_ROWS] = skip;
    cfg_valid <= 1'b1;
    for (int i = 0; i <= int'(REG_SKIP_ROWS); i++) begin
      cfg_index <= reg_idx_t'(i);
      cfg_data  <= setting[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // striped: rows go empty, empty, full, full so every row end past the skip
  // shows an edge and two poles close every four rows
  task automatic send_stream(input int count, input bit striped);
    int         density;
    bit         want;
    logic [7:0] u, y0, v, y1;
    density = 50;
    for (int k = 0; k < count; k++) begin
      if (row_pos == 0) begin
        stripe_row++;
        if (striped) begin
          pace = ($urandom_range(0, 3) == 0) ? PACE_NONE : PACE_SPARSE;
        end else begin
          pace    = pace_t'($urandom_range(0, 2));
          density = densities[$urandom_range(0, 4)];
        end
      end
      if (!striped && $urandom_range(0, 9) == 0) begin
        {y1, v, y0, u} = $urandom();
      end else begin
        want = striped ? ((stripe_row % 4) >= 2) : ($urandom_range(0, 99) < density);
        if (want) begin
          u  = pick_inside(setting[REG_BLUE_MIN], setting[REG_BLUE_MAX]);
          y0 = pick_inside(setting[REG_LUMA_MIN], setting[REG_LUMA_MAX]);
          v  = pick_inside(setting[REG_RED_MIN], setting[REG_RED_MAX]);
          y1 = 8'($urandom());
        end else begin
          {y1, v, y0, u} = $urandom();
          if (!spans_all(setting[REG_LUMA_MIN], setting[REG_LUMA_MAX]))
            y0 = pick_outside(setting[REG_LUMA_MIN], setting[REG_LUMA_MAX]);
          else if (!spans_all(setting[REG_BLUE_MIN], setting[REG_BLUE_MAX]))
            u = pick_outside(setting[REG_BLUE_MIN], setting[REG_BLUE_MAX]);
          else if (!spans_all(setting[REG_RED_MIN], setting[REG_RED_MAX]))
            v = pick_outside(setting[REG_RED_MIN], setting[REG_RED_MAX]);
        end
      end
      send_item(u, y0, v, y1);
    end
  endtask

  initial begin
    logic [7:0] a, b, c;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // window bounds at reset values; second Y never takes part in the test
    send_item(8'd0, 8'd0, 8'd0, 8'd0);
    send_item(8'd255, 8'd255, 8'd255, 8'd255);
    send_item(8'hAA, 8'h55, 8'hAA, 8'h55);
    send_item(8'h55, 8'hAA, 8'h55, 8'hAA);
    send_item(8'd45, 8'd26, 8'd160, 8'd0);
    send_item(8'd130, 8'd164, 8'd192, 8'd255);
    send_item(8'd45, 8'd25, 8'd160, 8'd7);
    send_item(8'd45, 8'd165, 8'd160, 8'd7);
    send_item(8'd44, 8'd26, 8'd160, 8'd7);
    send_item(8'd131, 8'd164, 8'd192, 8'd7);
    send_item(8'd45, 8'd26, 8'd159, 8'd7);
    send_item(8'd130, 8'd164, 8'd193, 8'd7);
    send_item(8'd100, 8'd100, 8'd170, 8'd0);
    send_item(8'd100, 8'd100, 8'd170, 8'd255);

    apply_settings(8'd26, 8'd164, 8'd45, 8'd130, 8'd160, 8'd192, 8'd34, 8'd8);
    send_stream(200, 1'b0);
    apply_settings(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0);
    send_stream(120, 1'b0);
    // inverted windows never match; threshold above any possible difference
    apply_settings(8'd200, 8'd100, 8'd255, 8'd0, 8'd129, 8'd128, 8'd255, 8'd255);
    send_stream(106, 1'b0);
    apply_settings(8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom()),
                   8'($urandom()), 8'($urandom()), 8'($urandom_range(0, 60)),
                   8'($urandom_range(0, 3)));
    send_stream(180, 1'b0);
    a = 8'($urandom());
    b = 8'($urandom());
    c = 8'($urandom());
    apply_settings(a, a, b, b, c, c, 8'd10, 8'd1);
    send_stream(100, 1'b0);

    // three rows of stripes starting on a row boundary: pole start and end edges
    apply_settings(8'd26, 8'd164, 8'd45, 8'd130, 8'd160, 8'd192, 8'd50, 8'd0);
    send_stream(3 * int'(MACROS_PER_ROW), 1'b1);

    drain_results();
    repeat (8) @(posedge clk);
    $display("run covered %0d macropixels (about %0d rows) under six register settings",
             items_sent, items_sent / int'(MACROS_PER_ROW));
    $display("checked %0d result items: %0d edges, %0d with saturated pole index",
             results_checked, edge_results, overflow_edges);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("color_mask_row_edge_detector_unit_tb passed");
    end else begin
      $display("color_mask_row_edge_detector_unit_tb failed");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("timeout with %0d result items still due", outstanding);
    $display("color_mask_row_edge_detector_unit_tb failed");
    $finish;
  end

endmodule
